FILE: design/nksl_pkg.sv
// shared types and constants of the nearest-k sorted list unit
`default_nettype none
package nksl_pkg;

   localparam int DIST_W          = 20;
   localparam int TAG_W           = 16;
   localparam int CMD_W           = 2;
   localparam int SLOT_W          = 4;
   localparam int LEN_W           = 5;
   localparam int TOTAL_W         = 16;
   localparam int MAX_ENTRIES_DEF = 16;

   localparam logic [DIST_W-1:0] RADIUS_RESET = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_OFFER = 2'd1,
      CMD_DUMP  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAIL,
      ST_LOOK,
      ST_SHIFT,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [TAG_W-1:0]  tag;
   } entry_type;

endpackage
`default_nettype wire

FILE: design/nksl_store.sv
// entry memory: one write port, one registered read port
`default_nettype none
module nksl_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire nksl_pkg::entry_type wr_entry,
   input  wire logic [AW-1:0]      rd_addr,
   output nksl_pkg::entry_type     rd_entry
);
   import nksl_pkg::*;

   entry_type store_ff [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= store_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule
`default_nettype wire

FILE: design/nksl_ctrl.sv
// sequencer with the shared compare unit, counters and response register
`default_nettype none
module nksl_ctrl #(
   parameter int MAX_ENTRIES = 16,
   parameter int IW          = 4,
   parameter int CW          = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [nksl_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [nksl_pkg::DIST_W-1:0]   req_offer_distance,
   input  wire logic [nksl_pkg::TAG_W-1:0]    req_offer_tag,
   input  wire logic                          csr_we,
   input  wire logic [nksl_pkg::DIST_W-1:0]   csr_wdata,
   output logic                               mem_wr_en,
   output logic [IW-1:0]                      mem_wr_addr,
   output nksl_pkg::entry_type                mem_wr_entry,
   output logic [IW-1:0]                      mem_rd_addr,
   input  wire nksl_pkg::entry_type           mem_rd_entry,
   output logic                               rsp_strobe,
   output logic                               rsp_kept,
   output logic [nksl_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [nksl_pkg::LEN_W-1:0]         rsp_list_length,
   output logic [nksl_pkg::TOTAL_W-1:0]       rsp_offered_total,
   output logic                               rsp_out_valid,
   output logic [nksl_pkg::DIST_W-1:0]        rsp_out_distance,
   output logic [nksl_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic                               rsp_last
);
   import nksl_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [DIST_W-1:0]   radius_ff, radius_in;
   logic [IW-1:0]       idx_ff, idx_in;
   entry_type           offer_ff, offer_in;
   cmd_type             cmd;
   logic                accept;
   logic                tail_drop;
   logic                shift_more;
   logic                dump_last;

   logic                strobe_ff, strobe_in;
   logic                kept_ff, kept_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [TOTAL_W-1:0]  rtotal_ff, rtotal_in;
   logic                valid_ff, valid_in;
   logic [DIST_W-1:0]   odist_ff, odist_in;
   logic [TAG_W-1:0]    otag_ff, otag_in;
   logic                last_ff, last_in;

   assign cmd        = cmd_type'(req_cmd);
   assign accept     = start && (state_ff == ST_IDLE);
   assign tail_drop  = offer_ff.distance >= mem_rd_entry.distance;
   assign shift_more = mem_rd_entry.distance > offer_ff.distance;
   assign dump_last  = (CW'(idx_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_OFFER: begin
                     if (req_offer_distance > radius_ff) begin
                        state_in = ST_IDLE;
                     end else if (count_ff < FULL_CNT) begin
                        state_in = ST_LOOK;
                     end else begin
                        state_in = ST_TAIL;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff != '0) begin
                        state_in = ST_DUMP;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TAIL: state_in = tail_drop ? ST_IDLE : ST_LOOK;
         ST_LOOK: state_in = (idx_ff == '0) ? ST_IDLE : ST_SHIFT;
         ST_SHIFT: begin
            if (!shift_more) begin
               state_in = ST_IDLE;
            end else if (idx_ff > IW'(1)) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_DUMP: state_in = dump_last ? ST_IDLE : ST_DUMP;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      total_in     = total_ff;
      radius_in    = csr_we ? csr_wdata : radius_ff;
      idx_in       = idx_ff;
      offer_in     = offer_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_entry = offer_ff;
      mem_rd_addr  = '0;
      strobe_in    = 1'b0;
      kept_in      = 1'b0;
      slot_in      = '0;
      valid_in     = 1'b0;
      odist_in     = '0;
      otag_in      = '0;
      last_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = (cmd == CMD_OFFER) ? LAST_IDX : '0;
            if (accept) begin
               offer_in.distance = req_offer_distance;
               offer_in.tag      = req_offer_tag;
               idx_in            = '0;
               case (cmd)
                  CMD_CLEAR: begin
                     count_in  = '0;
                     total_in  = '0;
                     strobe_in = 1'b1;
                     last_in   = 1'b1;
                  end
                  CMD_OFFER: begin
                     if (total_ff != '1) begin
                        total_in = total_ff + TOTAL_W'(1);
                     end
                     if (req_offer_distance > radius_ff) begin
                        strobe_in = 1'b1;
                        last_in   = 1'b1;
                     end else if (count_ff < FULL_CNT) begin
                        idx_in   = IW'(count_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        last_in   = 1'b1;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     last_in   = 1'b1;
                  end
               endcase
            end
         end
         ST_TAIL: begin
            idx_in = LAST_IDX;
            if (tail_drop) begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
            end
         end
         ST_LOOK: begin
            mem_rd_addr = idx_ff - IW'(1);
            if (idx_ff == '0) begin
               mem_wr_en = 1'b1;
               strobe_in = 1'b1;
               kept_in   = 1'b1;
               last_in   = 1'b1;
            end
         end
         ST_SHIFT: begin
            mem_wr_en = 1'b1;
            slot_in   = SLOT_W'(idx_ff);
            if (shift_more) begin
               mem_wr_entry = mem_rd_entry;
               idx_in       = idx_ff - IW'(1);
               mem_rd_addr  = (idx_ff > IW'(1)) ? idx_ff - IW'(2) : '0;
            end else begin
               strobe_in = 1'b1;
               kept_in   = 1'b1;
               last_in   = 1'b1;
            end
         end
         ST_DUMP: begin
            mem_rd_addr = dump_last ? '0 : idx_ff + IW'(1);
            idx_in      = idx_ff + IW'(1);
            strobe_in   = 1'b1;
            slot_in     = SLOT_W'(idx_ff);
            valid_in    = 1'b1;
            odist_in    = mem_rd_entry.distance;
            otag_in     = mem_rd_entry.tag;
            last_in     = dump_last;
         end
         default: mem_rd_addr = '0;
      endcase
      len_in    = LEN_W'(count_in);
      rtotal_in = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         total_ff  <= '0;
         radius_ff <= RADIUS_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         radius_ff <= radius_in;
         strobe_ff <= strobe_in;
      end
      idx_ff    <= idx_in;
      offer_ff  <= offer_in;
      kept_ff   <= kept_in;
      slot_ff   <= slot_in;
      len_ff    <= len_in;
      rtotal_ff <= rtotal_in;
      valid_ff  <= valid_in;
      odist_ff  <= odist_in;
      otag_ff   <= otag_in;
      last_ff   <= last_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = strobe_ff;
   assign rsp_kept          = kept_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_list_length   = len_ff;
   assign rsp_offered_total = rtotal_ff;
   assign rsp_out_valid     = valid_ff;
   assign rsp_out_distance  = odist_ff;
   assign rsp_out_tag       = otag_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

FILE: design/nearest_k_sorted_list_unit.sv
// top level of the nearest-k sorted list unit
//
// channel   ports                          handshake
// request   req_cmd, req_offer_*           start high while busy low takes the word
// response  rsp_*                          rsp_strobe high for one cycle per word
// csr       csr_wdata                      csr_we high writes radius_limit
//
// clear, unused command, empty dump, offer beyond radius: handled in idle, word the cycle after
// offer kept: idle, tail when the list is full, look, then shift while entries move down
// offer dropped at the tail of a full list: idle, then tail; one compare per cycle throughout
// dump: one word per cycle, one word per entry, paced by the entry memory read port
// reset is synchronous and empties the list; words cannot be held off
`default_nettype none
module nearest_k_sorted_list_unit #(
   parameter int MAX_ENTRIES = nksl_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [nksl_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [nksl_pkg::DIST_W-1:0]   req_offer_distance,
   input  wire logic [nksl_pkg::TAG_W-1:0]    req_offer_tag,
   input  wire logic                          csr_we,
   input  wire logic [nksl_pkg::DIST_W-1:0]   csr_wdata,
   output logic                               rsp_strobe,
   output logic                               rsp_kept,
   output logic [nksl_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [nksl_pkg::LEN_W-1:0]         rsp_list_length,
   output logic [nksl_pkg::TOTAL_W-1:0]       rsp_offered_total,
   output logic                               rsp_out_valid,
   output logic [nksl_pkg::DIST_W-1:0]        rsp_out_distance,
   output logic [nksl_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic                               rsp_last
);
   import nksl_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic            mem_wr_en;
   logic [IW-1:0]   mem_wr_addr;
   entry_type       mem_wr_entry;
   logic [IW-1:0]   mem_rd_addr;
   entry_type       mem_rd_entry;

   nksl_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IW          (IW),
      .CW          (CW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_offer_distance (req_offer_distance),
      .req_offer_tag      (req_offer_tag),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_entry       (mem_wr_entry),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_entry       (mem_rd_entry),
      .rsp_strobe         (rsp_strobe),
      .rsp_kept           (rsp_kept),
      .rsp_slot           (rsp_slot),
      .rsp_list_length    (rsp_list_length),
      .rsp_offered_total  (rsp_offered_total),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_distance   (rsp_out_distance),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_last           (rsp_last)
   );

   nksl_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (IW)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

   a_clear_word: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_CLEAR |=>
         rsp_strobe && rsp_last && rsp_list_length == '0 && rsp_offered_total == '0)
      else $error("clear word wrong");

   a_kept_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kept |-> !rsp_out_valid && rsp_last)
      else $error("kept word carries entry data");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe && rsp_last)
      else $error("operation ended without last word");

   a_dump_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_out_valid)
      else $error("dump run broken");

endmodule
`default_nettype wire

FILE: verif/nearest_k_sorted_list_unit_test.sv
// self-checking testbench of the nearest-k sorted list unit with a scoreboard class
`timescale 1ns / 100ps
module nearest_k_sorted_list_unit_test;
   import nksl_pkg::*;

   localparam int LIST_DEPTH = MAX_ENTRIES_DEF;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic               kept;
      logic [SLOT_W-1:0]  slot;
      logic [LEN_W-1:0]   length;
      logic [TOTAL_W-1:0] total;
      logic               valid;
      logic [DIST_W-1:0]  distance;
      logic [TAG_W-1:0]   tag;
      logic               last;
   } list_word_type;

   class list_scoreboard_type;
      logic [DIST_W-1:0]  radius;
      logic [DIST_W-1:0]  dist_q [LIST_DEPTH];
      logic [TAG_W-1:0]   tag_q [LIST_DEPTH];
      int                 count;
      logic [TOTAL_W-1:0] total;
      list_word_type      pending_q [$];
      int                 failures;

      function new();
         radius = RADIUS_RESET;
         count = 0;
         total = 0;
         failures = 0;
      endfunction

      function void push_word(logic kept, int slot, logic valid, logic [DIST_W-1:0] d,
                              logic [TAG_W-1:0] t, logic last);
         list_word_type w;
         w.kept = kept;
         w.slot = slot[SLOT_W-1:0];
         w.length = count[LEN_W-1:0];
         w.total = total;
         w.valid = valid;
         w.distance = d;
         w.tag = t;
         w.last = last;
         pending_q.push_back(w);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] d,
                                 logic [TAG_W-1:0] t);
         int   pos;
         logic keep;
         pos = 0;
         keep = 1'b1;
         case (cmd)
            CMD_CLEAR: begin
               count = 0;
               total = 0;
               push_word(1'b0, 0, 1'b0, '0, '0, 1'b1);
            end
            CMD_OFFER: begin
               if (total != '1) total++;
               if (d > radius) begin
                  keep = 1'b0;
               end else if (count < LIST_DEPTH) begin
                  pos = count;
                  count++;
               end else if (d >= dist_q[LIST_DEPTH-1]) begin
                  keep = 1'b0;
               end else begin
                  pos = LIST_DEPTH - 1;
               end
               if (keep) begin
                  while (pos > 0 && dist_q[pos-1] > d) begin
                     dist_q[pos] = dist_q[pos-1];
                     tag_q[pos] = tag_q[pos-1];
                     pos--;
                  end
                  dist_q[pos] = d;
                  tag_q[pos] = t;
               end
               push_word(keep, pos, 1'b0, '0, '0, 1'b1);
            end
            CMD_DUMP: begin
               if (count == 0) push_word(1'b0, 0, 1'b0, '0, '0, 1'b1);
               for (int k = 0; k < count; k++)
                  push_word(1'b0, k, 1'b1, dist_q[k], tag_q[k], k == count - 1);
            end
            default: begin
               push_word(1'b0, 0, 1'b0, '0, '0, 1'b1);
            end
         endcase
      endfunction

      function void check_word(list_word_type got);
         list_word_type exp;
         if (pending_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: slot %0d dist %0d tag %0d last %0d",
                        got.slot, got.distance, got.tag, got.last);
            return;
         end
         exp = pending_q.pop_front();
         if (got !== exp) begin
            failures++;
            if (failures <= 10)
               $display({"word mismatch (kept slot len total valid dist tag last): ",
                         "exp %0d %0d %0d %0d %0d %0d %0d %0d, ",
                         "got %0d %0d %0d %0d %0d %0d %0d %0d"},
                        exp.kept, exp.slot, exp.length, exp.total, exp.valid,
                        exp.distance, exp.tag, exp.last, got.kept, got.slot,
                        got.length, got.total, got.valid, got.distance, got.tag,
                        got.last);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [CMD_W-1:0]   req_cmd;
   logic [DIST_W-1:0]  req_offer_distance;
   logic [TAG_W-1:0]   req_offer_tag;
   logic               csr_we;
   logic [DIST_W-1:0]  csr_wdata;
   logic               rsp_strobe;
   logic               rsp_kept;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [LEN_W-1:0]   rsp_list_length;
   logic [TOTAL_W-1:0] rsp_offered_total;
   logic               rsp_out_valid;
   logic [DIST_W-1:0]  rsp_out_distance;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic               rsp_last;

   list_scoreboard_type sb;

   nearest_k_sorted_list_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_offer_distance (req_offer_distance),
      .req_offer_tag      (req_offer_tag),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_kept           (rsp_kept),
      .rsp_slot           (rsp_slot),
      .rsp_list_length    (rsp_list_length),
      .rsp_offered_total  (rsp_offered_total),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_distance   (rsp_out_distance),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         sb.check_word({rsp_kept, rsp_slot, rsp_list_length, rsp_offered_total,
                        rsp_out_valid, rsp_out_distance, rsp_out_tag, rsp_last});
   end

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance(logic [DIST_W-1:0] r);
      case ($urandom_range(0, 9))
         0, 1, 2: return DIST_W'($urandom_range(0, 15));
         3, 4, 5: return DIST_W'($urandom);
         6:       return r;
         7:       return (r == DIST_MAX) ? r : r + 1'b1;
         8:       return '0;
         default: return DIST_MAX;
      endcase
   endfunction

   // called and left at a falling edge
   task automatic issue_word(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] d,
                             logic [TAG_W-1:0] t, int gap);
      req_cmd = cmd;
      req_offer_distance = d;
      req_offer_tag = t;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(cmd, d, t);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      start = 1'b0;
      @(negedge clock);
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
   endtask

   task automatic set_radius(logic [DIST_W-1:0] r);
      wait_idle();
      csr_we = 1'b1;
      csr_wdata = r;
      @(negedge clock);
      csr_we = 1'b0;
      sb.radius = r;
   endtask

   initial begin
      logic [DIST_W-1:0] r;
      bit                quiet;
      int                sel;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_CLEAR;
      req_offer_distance = '0;
      req_offer_tag = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words: empty dump, spare code, extremes, ties, radius edge
      issue_word(CMD_DUMP, '0, '0, 0);
      issue_word(CMD_SPARE, DIST_MAX, '1, 1);
      issue_word(CMD_OFFER, '0, '0, 0);
      issue_word(CMD_OFFER, DIST_MAX, '1, 0);
      issue_word(CMD_OFFER, 20'd5, 16'h000a, 2);
      issue_word(CMD_OFFER, 20'd5, 16'h000b, 0);
      issue_word(CMD_OFFER, 20'd3, 16'h000c, 0);
      issue_word(CMD_OFFER, 20'd5, 16'h000d, 0);
      issue_word(CMD_SPARE, '0, '0, 0);
      issue_word(CMD_DUMP, '0, '0, 0);
      issue_word(CMD_CLEAR, DIST_MAX, '1, 0);
      issue_word(CMD_DUMP, '0, '0, 0);
      set_radius(20'd100);
      issue_word(CMD_OFFER, 20'd100, 16'h5555, 0);
      issue_word(CMD_OFFER, 20'd101, 16'haaaa, 0);
      issue_word(CMD_OFFER, DIST_MAX, 16'hffff, 0);
      issue_word(CMD_OFFER, 20'd99, 16'h0001, 0);
      issue_word(CMD_DUMP, '0, '0, 0);

      for (int round = 0; round < 4; round++) begin
         case (round)
            0:       r = DIST_MAX;
            1:       r = DIST_W'($urandom_range(1000, 900000));
            2:       r = '0;
            default: r = DIST_W'($urandom_range(8, 3000));
         endcase
         set_radius(r);
         quiet = ($urandom_range(0, 2) == 0);
         issue_word(CMD_CLEAR, DIST_W'($urandom), TAG_W'($urandom), pick_gap(quiet));
         for (int k = 0; k < 20; k++) begin
            sel = $urandom_range(0, 39);
            if (sel < 3)
               issue_word(CMD_DUMP, DIST_W'($urandom), TAG_W'($urandom), pick_gap(quiet));
            else if (sel < 5)
               issue_word(CMD_SPARE, DIST_W'($urandom), TAG_W'($urandom), pick_gap(quiet));
            else if (sel < 6)
               issue_word(CMD_CLEAR, DIST_W'($urandom), TAG_W'($urandom), pick_gap(quiet));
            else
               issue_word(CMD_OFFER, pick_distance(r), TAG_W'($urandom), pick_gap(quiet));
         end
         issue_word(CMD_DUMP, '0, '0, pick_gap(quiet));
      end

      set_radius('0);
      issue_word(CMD_DUMP, '0, '0, 0);
      issue_word(CMD_OFFER, '0, 16'h1234, 0);
      issue_word(CMD_DUMP, '0, '0, 0);

      wait_idle();
      repeat (20) @(negedge clock);
      sb.failures += sb.pending_q.size();
      if (sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/nksl_pkg.sv
design/nksl_store.sv
design/nksl_ctrl.sv
design/nearest_k_sorted_list_unit.sv
verif/nearest_k_sorted_list_unit_test.sv
